// File: rtl/core/dll_pkg.sv
// ----------------------------------------------------------------------------
// Doubly linked list engine package
// Sizes, link encoding, operation and status codes, and controller states.
// ----------------------------------------------------------------------------
package dll_pkg;

  localparam int CAPACITY   = 32;
  localparam int VALUE_BITS = 32;

  localparam int SLOT_W = $clog2(CAPACITY);
  localparam int LINK_W = SLOT_W + 1;
  localparam int CNT_W  = $clog2(CAPACITY + 1);
  localparam int CMP_W  = ((CNT_W > 6) ? CNT_W : 6) + 1;

  localparam logic [LINK_W-1:0] NIL = LINK_W'(CAPACITY);

  typedef enum logic [2:0] {
    OP_INS_FIRST = 3'd0,
    OP_INS_END   = 3'd1,
    OP_INS_AT    = 3'd2,
    OP_DEL_FIRST = 3'd3,
    OP_DEL_END   = 3'd4,
    OP_DEL_AT    = 3'd5,
    OP_LIST      = 3'd6,
    OP_NONE      = 3'd7
  } op_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_BAD_PLACE = 2'd1,
    ST_UNDERFLOW = 2'd2,
    ST_FULL      = 2'd3
  } status_e;

  typedef enum logic [9:0] {
    S_IDLE   = 10'b0000000001,
    S_ALLOC  = 10'b0000000010,
    S_PREP   = 10'b0000000100,
    S_WALK   = 10'b0000001000,
    S_LINK1  = 10'b0000010000,
    S_LINK2  = 10'b0000100000,
    S_UNLINK = 10'b0001000000,
    S_FREE   = 10'b0010000000,
    S_LIST   = 10'b0100000000,
    S_RESP   = 10'b1000000000
  } state_e;

endpackage

// File: rtl/core/dll_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port; read data is registered and holds its
// value while no read is issued.
// ----------------------------------------------------------------------------
module dll_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

// File: rtl/core/doubly_linked_list_engine_unit.sv
// ----------------------------------------------------------------------------
// Doubly linked list engine
// Ordered list of signed values kept in node memories with forward and
// backward links and a free list of recycled slots.
// ----------------------------------------------------------------------------
// One transaction is taken at a time. Positional inserts and deletes walk the
// forward links from the head, and listing delivers one result per cycle while
// the output is not stalled. The walk is limited by the single read port of the
// forward link memory, which is followed one node per cycle.
module doubly_linked_list_engine_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         operation_i,
  input  logic [5:0]         position_i,
  input  logic signed [31:0] value_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic signed [31:0] element_o,
  output logic               has_element_o,
  output logic [5:0]         element_place_o,
  output logic [5:0]         length_o,
  output logic               last_o
);

  localparam int SW = dll_pkg::SLOT_W;
  localparam int LW = dll_pkg::LINK_W;
  localparam int CW = dll_pkg::CNT_W;
  localparam int VW = dll_pkg::VALUE_BITS;
  localparam int MW = dll_pkg::CMP_W;

  dll_pkg::state_e    state_q, state_d;
  dll_pkg::op_e       op_q, op_d;
  dll_pkg::status_e   rsp_q, rsp_d;
  logic [5:0]         pos_q, pos_d;
  logic [VW-1:0]      val_q, val_d;
  logic [LW-1:0]      head_q, head_d, tail_q, tail_d, fhead_q, fhead_d;
  logic [LW-1:0]      slot_q, slot_d, prev_q, prev_d, next_q, next_d, cur_q, cur_d;
  logic [CW-1:0]      count_q, count_d, fresh_q, fresh_d, idx_q, idx_d, tgt_q, tgt_d;

  logic               out_valid_q, out_valid_d;
  logic [1:0]         ost_q, ost_d;
  logic [31:0]        oel_q, oel_d;
  logic               ohas_q, ohas_d, olast_q, olast_d;
  logic [5:0]         oplace_q, oplace_d, olen_q, olen_d;

  logic               rd_en;
  logic [SW-1:0]      rd_addr;
  logic               val_we, fwd_we, bwd_we;
  logic [SW-1:0]      val_waddr, fwd_waddr, bwd_waddr;
  logic [LW-1:0]      fwd_wdata, bwd_wdata, fwd_rdata, bwd_rdata;
  logic [VW-1:0]      val_rdata;

  logic               out_free, is_ins;
  logic [MW-1:0]      pos_w, cnt_w;

  assign out_free = !out_valid_q || out_ready_i;
  assign is_ins   = (op_q == dll_pkg::OP_INS_FIRST) || (op_q == dll_pkg::OP_INS_END) ||
                    (op_q == dll_pkg::OP_INS_AT);
  assign pos_w    = MW'(position_i);
  assign cnt_w    = MW'(count_q);

  always_comb begin
    state_d     = state_q;
    op_d        = op_q;
    rsp_d       = rsp_q;
    pos_d       = pos_q;
    val_d       = val_q;
    head_d      = head_q;
    tail_d      = tail_q;
    fhead_d     = fhead_q;
    slot_d      = slot_q;
    prev_d      = prev_q;
    next_d      = next_q;
    cur_d       = cur_q;
    count_d     = count_q;
    fresh_d     = fresh_q;
    idx_d       = idx_q;
    tgt_d       = tgt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    ost_d       = ost_q;
    oel_d       = oel_q;
    ohas_d      = ohas_q;
    oplace_d    = oplace_q;
    olen_d      = olen_q;
    olast_d     = olast_q;
    rd_en       = 1'b0;
    rd_addr     = cur_q[SW-1:0];
    val_we      = 1'b0;
    fwd_we      = 1'b0;
    bwd_we      = 1'b0;
    val_waddr   = slot_q[SW-1:0];
    fwd_waddr   = slot_q[SW-1:0];
    bwd_waddr   = slot_q[SW-1:0];
    fwd_wdata   = next_q;
    bwd_wdata   = prev_q;

    case (state_q)
      dll_pkg::S_IDLE: begin
        if (in_valid_i) begin
          op_d  = dll_pkg::op_e'(operation_i);
          pos_d = position_i;
          val_d = VW'(value_i);
          rsp_d = dll_pkg::ST_OK;
          state_d = dll_pkg::S_RESP;
          case (operation_i)
            dll_pkg::OP_INS_FIRST, dll_pkg::OP_INS_END, dll_pkg::OP_INS_AT: begin
              if (operation_i == dll_pkg::OP_INS_AT &&
                  (pos_w == '0 || pos_w > cnt_w + MW'(1))) begin
                rsp_d = dll_pkg::ST_BAD_PLACE;
              end else if (count_q == CW'(dll_pkg::CAPACITY)) begin
                rsp_d = dll_pkg::ST_FULL;
              end else if (fhead_q != dll_pkg::NIL) begin
                rd_en   = 1'b1;
                rd_addr = fhead_q[SW-1:0];
                slot_d  = fhead_q;
                state_d = dll_pkg::S_ALLOC;
              end else begin
                slot_d  = LW'(fresh_q);
                fresh_d = fresh_q + CW'(1);
                state_d = dll_pkg::S_PREP;
              end
            end
            dll_pkg::OP_DEL_FIRST, dll_pkg::OP_DEL_END, dll_pkg::OP_DEL_AT: begin
              if (count_q == '0) begin
                rsp_d = dll_pkg::ST_UNDERFLOW;
              end else if (operation_i == dll_pkg::OP_DEL_AT &&
                           (pos_w == '0 || pos_w > cnt_w)) begin
                rsp_d = dll_pkg::ST_BAD_PLACE;
              end else begin
                cur_d   = (operation_i == dll_pkg::OP_DEL_END) ? tail_q : head_q;
                tgt_d   = (operation_i == dll_pkg::OP_DEL_AT) ? CW'(position_i) : CW'(1);
                idx_d   = CW'(1);
                rd_en   = 1'b1;
                rd_addr = cur_d[SW-1:0];
                state_d = dll_pkg::S_WALK;
              end
            end
            dll_pkg::OP_LIST: begin
              if (count_q != '0) begin
                cur_d   = head_q;
                idx_d   = CW'(1);
                rd_en   = 1'b1;
                rd_addr = head_q[SW-1:0];
                state_d = dll_pkg::S_LIST;
              end
            end
            default: begin
              rsp_d = dll_pkg::ST_OK;
            end
          endcase
        end
      end
      dll_pkg::S_ALLOC: begin
        fhead_d = fwd_rdata;
        state_d = dll_pkg::S_PREP;
      end
      dll_pkg::S_PREP: begin
        if (op_q == dll_pkg::OP_INS_FIRST || count_q == '0 ||
            (op_q == dll_pkg::OP_INS_AT && pos_q == 6'd1)) begin
          prev_d  = dll_pkg::NIL;
          next_d  = head_q;
          state_d = dll_pkg::S_LINK1;
        end else begin
          cur_d   = (op_q == dll_pkg::OP_INS_END) ? tail_q : head_q;
          tgt_d   = (op_q == dll_pkg::OP_INS_END) ? CW'(1) : CW'(pos_q) - CW'(1);
          idx_d   = CW'(1);
          rd_en   = 1'b1;
          rd_addr = cur_d[SW-1:0];
          state_d = dll_pkg::S_WALK;
        end
      end
      dll_pkg::S_WALK: begin
        if (idx_q == tgt_q) begin
          next_d = fwd_rdata;
          if (is_ins) begin
            prev_d  = cur_q;
            state_d = dll_pkg::S_LINK1;
          end else begin
            slot_d  = cur_q;
            prev_d  = bwd_rdata;
            state_d = dll_pkg::S_UNLINK;
          end
        end else begin
          cur_d   = fwd_rdata;
          idx_d   = idx_q + CW'(1);
          rd_en   = 1'b1;
          rd_addr = fwd_rdata[SW-1:0];
        end
      end
      dll_pkg::S_LINK1: begin
        val_we  = 1'b1;
        fwd_we  = 1'b1;
        bwd_we  = 1'b1;
        state_d = dll_pkg::S_LINK2;
      end
      dll_pkg::S_LINK2: begin
        if (prev_q == dll_pkg::NIL) begin
          head_d = slot_q;
        end else begin
          fwd_we    = 1'b1;
          fwd_waddr = prev_q[SW-1:0];
          fwd_wdata = slot_q;
        end
        if (next_q == dll_pkg::NIL) begin
          tail_d = slot_q;
        end else begin
          bwd_we    = 1'b1;
          bwd_waddr = next_q[SW-1:0];
          bwd_wdata = slot_q;
        end
        count_d = count_q + CW'(1);
        state_d = dll_pkg::S_RESP;
      end
      dll_pkg::S_UNLINK: begin
        if (prev_q == dll_pkg::NIL) begin
          head_d = next_q;
        end else begin
          fwd_we    = 1'b1;
          fwd_waddr = prev_q[SW-1:0];
          fwd_wdata = next_q;
        end
        if (next_q == dll_pkg::NIL) begin
          tail_d = prev_q;
        end else begin
          bwd_we    = 1'b1;
          bwd_waddr = next_q[SW-1:0];
          bwd_wdata = prev_q;
        end
        state_d = dll_pkg::S_FREE;
      end
      dll_pkg::S_FREE: begin
        fwd_we    = 1'b1;
        fwd_wdata = fhead_q;
        fhead_d   = slot_q;
        count_d   = count_q - CW'(1);
        state_d   = dll_pkg::S_RESP;
      end
      dll_pkg::S_LIST: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ost_d       = dll_pkg::ST_OK;
          oel_d       = 32'(val_rdata);
          ohas_d      = 1'b1;
          oplace_d    = 6'(idx_q);
          olen_d      = 6'(count_q);
          olast_d     = (idx_q == count_q) || (fwd_rdata == dll_pkg::NIL);
          if (olast_d) begin
            state_d = dll_pkg::S_IDLE;
          end else begin
            cur_d   = fwd_rdata;
            idx_d   = idx_q + CW'(1);
            rd_en   = 1'b1;
            rd_addr = fwd_rdata[SW-1:0];
          end
        end
      end
      dll_pkg::S_RESP: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          ost_d       = rsp_q;
          oel_d       = '0;
          ohas_d      = 1'b0;
          oplace_d    = '0;
          olen_d      = 6'(count_q);
          olast_d     = 1'b1;
          state_d     = dll_pkg::S_IDLE;
        end
      end
      default: begin
        state_d = dll_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dll_pkg::S_IDLE;
      head_q      <= dll_pkg::NIL;
      tail_q      <= dll_pkg::NIL;
      fhead_q     <= dll_pkg::NIL;
      count_q     <= '0;
      fresh_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      fhead_q     <= fhead_d;
      count_q     <= count_d;
      fresh_q     <= fresh_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    rsp_q    <= rsp_d;
    pos_q    <= pos_d;
    val_q    <= val_d;
    slot_q   <= slot_d;
    prev_q   <= prev_d;
    next_q   <= next_d;
    cur_q    <= cur_d;
    idx_q    <= idx_d;
    tgt_q    <= tgt_d;
    ost_q    <= ost_d;
    oel_q    <= oel_d;
    ohas_q   <= ohas_d;
    oplace_q <= oplace_d;
    olen_q   <= olen_d;
    olast_q  <= olast_d;
  end

  dll_ram #(.WIDTH(VW), .DEPTH(dll_pkg::CAPACITY)) u_val_ram (
    .clk_i   (clk_i),
    .we_i    (val_we),
    .waddr_i (val_waddr),
    .wdata_i (val_q),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (val_rdata)
  );

  dll_ram #(.WIDTH(LW), .DEPTH(dll_pkg::CAPACITY)) u_fwd_ram (
    .clk_i   (clk_i),
    .we_i    (fwd_we),
    .waddr_i (fwd_waddr),
    .wdata_i (fwd_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (fwd_rdata)
  );

  dll_ram #(.WIDTH(LW), .DEPTH(dll_pkg::CAPACITY)) u_bwd_ram (
    .clk_i   (clk_i),
    .we_i    (bwd_we),
    .waddr_i (bwd_waddr),
    .wdata_i (bwd_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (bwd_rdata)
  );

  assign in_ready_o      = (state_q == dll_pkg::S_IDLE);
  assign out_valid_o     = out_valid_q;
  assign status_o        = ost_q;
  assign element_o       = oel_q;
  assign has_element_o   = ohas_q;
  assign element_place_o = oplace_q;
  assign length_o        = olen_q;
  assign last_o          = olast_q;

endmodule

// File: test/tb_top.sv
// ----------------------------------------------------------------------------
// Doubly linked list engine testbench
// Drives insert, delete and list requests through the valid/ready input
// channel, predicts every result with a behavioral list model and checks each
// result transaction field by field under random idling on both sides.
// ----------------------------------------------------------------------------
module tb_top;

  typedef struct packed {
    logic [2:0]         operation;
    logic [5:0]         position;
    logic signed [31:0] value;
  } request_t;

  typedef struct packed {
    logic [1:0]         status;
    logic signed [31:0] element;
    logic               has_element;
    logic [5:0]         element_place;
    logic [5:0]         length;
    logic               last;
  } answer_t;

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [2:0]         operation_i;
  logic [5:0]         position_i;
  logic signed [31:0] value_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [1:0]         status_o;
  logic signed [31:0] element_o;
  logic               has_element_o;
  logic [5:0]         element_place_o;
  logic [5:0]         length_o;
  logic               last_o;

  request_t     pending_requests[$];
  answer_t      expected_answers[$];
  logic [31:0]  list_values[$];
  int           send_idle_pct;
  int           recv_idle_pct;
  bit           hold_sender;
  int           error_count;
  int           requests_sent;
  int           answers_seen;
  int           max_length_seen;

  doubly_linked_list_engine_unit i_dut (
    .clk_i, .rst_ni, .in_valid_i, .in_ready_o, .operation_i, .position_i,
    .value_i, .out_valid_o, .out_ready_i, .status_o, .element_o,
    .has_element_o, .element_place_o, .length_o, .last_o
  );

  initial begin
    clk_i = 1'b0;
    forever #6 clk_i = ~clk_i;
  end

  function automatic answer_t make_answer(logic [1:0] st, logic [31:0] el, logic has,
                                          logic [5:0] place, logic lst);
    answer_t a;
    a.status = st;
    a.element = el;
    a.has_element = has;
    a.element_place = place;
    a.length = 6'(list_values.size());
    a.last = lst;
    return a;
  endfunction

  task automatic predict_list_answers(request_t r);
    int count;
    logic [1:0] st;
    count = list_values.size();
    st = dll_pkg::ST_OK;
    case (r.operation)
      dll_pkg::OP_INS_FIRST, dll_pkg::OP_INS_END, dll_pkg::OP_INS_AT: begin
        if (r.operation == dll_pkg::OP_INS_AT &&
            (r.position < 1 || r.position > count + 1)) begin
          st = dll_pkg::ST_BAD_PLACE;
        end else if (count >= dll_pkg::CAPACITY) begin
          st = dll_pkg::ST_FULL;
        end else if (r.operation == dll_pkg::OP_INS_FIRST) begin
          list_values.push_front(r.value);
        end else if (r.operation == dll_pkg::OP_INS_END) begin
          list_values.push_back(r.value);
        end else begin
          list_values.insert(r.position - 1, r.value);
        end
      end
      dll_pkg::OP_DEL_FIRST, dll_pkg::OP_DEL_END, dll_pkg::OP_DEL_AT: begin
        if (count == 0) begin
          st = dll_pkg::ST_UNDERFLOW;
        end else if (r.operation == dll_pkg::OP_DEL_AT &&
                     (r.position < 1 || r.position > count)) begin
          st = dll_pkg::ST_BAD_PLACE;
        end else if (r.operation == dll_pkg::OP_DEL_FIRST) begin
          void'(list_values.pop_front());
        end else if (r.operation == dll_pkg::OP_DEL_END) begin
          void'(list_values.pop_back());
        end else begin
          list_values.delete(r.position - 1);
        end
      end
      dll_pkg::OP_LIST: begin
        if (count == 0) begin
          expected_answers.push_back(make_answer(dll_pkg::ST_OK, '0, 1'b0, '0, 1'b1));
        end else begin
          for (int i = 0; i < count; i++) begin
            expected_answers.push_back(make_answer(dll_pkg::ST_OK, list_values[i], 1'b1,
                                                   6'(i + 1), i == count - 1));
          end
        end
        return;
      end
      default: ;
    endcase
    if (list_values.size() > max_length_seen) max_length_seen = list_values.size();
    expected_answers.push_back(make_answer(st, '0, 1'b0, '0, 1'b1));
  endtask

  function automatic request_t random_request();
    request_t r;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) r.operation = dll_pkg::OP_INS_END;
    else if (pick < 35) r.operation = dll_pkg::OP_INS_AT;
    else if (pick < 45) r.operation = dll_pkg::OP_INS_FIRST;
    else if (pick < 55) r.operation = dll_pkg::OP_DEL_AT;
    else if (pick < 63) r.operation = dll_pkg::OP_DEL_FIRST;
    else if (pick < 71) r.operation = dll_pkg::OP_DEL_END;
    else if (pick < 90) r.operation = dll_pkg::OP_LIST;
    else r.operation = 3'($urandom_range(0, 7));
    r.position = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'($urandom_range(1, 20));
    r.value = $urandom;
    return r;
  endfunction

  function automatic request_t req(logic [2:0] op, logic [5:0] pos, logic [31:0] val);
    request_t r;
    r.operation = op;
    r.position = pos;
    r.value = val;
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      operation_i <= '0;
      position_i <= '0;
      value_i <= '0;
    end else if (!in_valid_i || in_ready_o) begin
      if (in_valid_i) begin
        predict_list_answers(req(operation_i, position_i, value_i));
        requests_sent++;
      end
      if (pending_requests.size() > 0 && !hold_sender &&
          $urandom_range(0, 99) >= send_idle_pct) begin
        request_t r;
        r = pending_requests.pop_front();
        in_valid_i <= 1'b1;
        operation_i <= r.operation;
        position_i <= r.position;
        value_i <= r.value;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        answer_t e;
        answers_seen++;
        if (expected_answers.size() == 0) begin
          $error("unexpected result transaction: status %0d element %0d", status_o, element_o);
          error_count++;
        end else begin
          e = expected_answers.pop_front();
          if (status_o !== e.status) begin
            $error("status: expected %0d, actual %0d", e.status, status_o);
            error_count++;
          end
          if (element_o !== e.element) begin
            $error("element: expected %0d, actual %0d", e.element, element_o);
            error_count++;
          end
          if (has_element_o !== e.has_element) begin
            $error("has_element: expected %0d, actual %0d", e.has_element, has_element_o);
            error_count++;
          end
          if (element_place_o !== e.element_place) begin
            $error("element_place: expected %0d, actual %0d", e.element_place,
                   element_place_o);
            error_count++;
          end
          if (length_o !== e.length) begin
            $error("length: expected %0d, actual %0d", e.length, length_o);
            error_count++;
          end
          if (last_o !== e.last) begin
            $error("last: expected %0d, actual %0d", e.last, last_o);
            error_count++;
          end
        end
      end
      out_ready_i <= ($urandom_range(0, 99) >= recv_idle_pct);
    end
  end

  task automatic wait_drained();
    while (pending_requests.size() > 0 || in_valid_i || expected_answers.size() > 0)
      @(posedge clk_i);
  endtask

  task automatic run_phase(int send_pct, int recv_pct, int n);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int i = 0; i < n; i++) pending_requests.push_back(random_request());
    wait_drained();
  endtask

  initial begin
    error_count = 0;
    requests_sent = 0;
    answers_seen = 0;
    max_length_seen = 0;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_sender = 1'b0;
    rst_ni = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Empty-list cases, edge values and positions, then fill to capacity.
    pending_requests.push_back(req(dll_pkg::OP_LIST, 6'd0, 32'd0));
    pending_requests.push_back(req(dll_pkg::OP_DEL_FIRST, 6'd0, 32'd0));
    pending_requests.push_back(req(dll_pkg::OP_DEL_END, 6'd0, 32'd0));
    pending_requests.push_back(req(dll_pkg::OP_DEL_AT, 6'd63, 32'd0));
    pending_requests.push_back(req(dll_pkg::OP_INS_AT, 6'd0, 32'd5));
    pending_requests.push_back(req(dll_pkg::OP_INS_AT, 6'd2, 32'd5));
    pending_requests.push_back(req(dll_pkg::OP_INS_FIRST, 6'd63, 32'h8000_0000));
    pending_requests.push_back(req(dll_pkg::OP_INS_END, 6'd0, 32'h7fff_ffff));
    pending_requests.push_back(req(dll_pkg::OP_INS_AT, 6'd2, 32'hffff_ffff));
    pending_requests.push_back(req(dll_pkg::OP_LIST, 6'd63, 32'hffff_ffff));
    pending_requests.push_back(req(dll_pkg::OP_DEL_AT, 6'd0, 32'd0));
    pending_requests.push_back(req(dll_pkg::OP_DEL_AT, 6'd4, 32'd0));
    pending_requests.push_back(req(dll_pkg::OP_DEL_AT, 6'd2, 32'd0));
    pending_requests.push_back(req(dll_pkg::OP_NONE, 6'd42, 32'h5555_aaaa));
    for (int i = 0; i < 31; i++) begin
      pending_requests.push_back(req(dll_pkg::OP_INS_END, 6'd0, $urandom));
    end
    pending_requests.push_back(req(dll_pkg::OP_INS_FIRST, 6'd0, 32'd1));
    pending_requests.push_back(req(dll_pkg::OP_INS_AT, 6'd33, 32'd1));
    pending_requests.push_back(req(dll_pkg::OP_INS_AT, 6'd34, 32'd1));
    pending_requests.push_back(req(dll_pkg::OP_LIST, 6'd0, 32'd0));
    pending_requests.push_back(req(dll_pkg::OP_DEL_AT, 6'd32, 32'd0));
    pending_requests.push_back(req(dll_pkg::OP_DEL_AT, 6'd33, 32'd0));
    wait_drained();

    hold_sender = 1'b1;
    pending_requests.push_back(req(dll_pkg::OP_LIST, 6'd0, 32'd0));
    repeat (50) @(posedge clk_i);
    hold_sender = 1'b0;
    wait_drained();

    run_phase(22, 85, 23);
    run_phase(85, 22, 23);
    run_phase(0, 0, 23);
    repeat (60) @(posedge clk_i);

    $display("Sent %0d requests and checked %0d result transactions,", requests_sent,
             answers_seen);
    $display("covering every operation, empty and full lists (peak length %0d).",
             max_length_seen);
    if (error_count == 0 && expected_answers.size() == 0) begin
      $display("doubly_linked_list_engine_unit regression: pass");
    end else begin
      $display("doubly_linked_list_engine_unit regression: fail");
    end
    $finish;
  end

  initial begin
    #6000000;
    $display("doubly_linked_list_engine_unit regression: fail");
    $finish;
  end

endmodule
